// File: rtl/rational_reduce_and_arith_unit_assert.svh
// assertion macros shared by the checker
`ifndef RATIONAL_REDUCE_AND_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_REDUCE_AND_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RRAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrau assertion failed");

// next-cycle implication, disabled in reset
`define RRAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrau assertion failed");

// next-cycle implication, always checked
`define RRAU_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rrau assertion failed");

`endif

// File: rtl/rrau_pkg.sv
`default_nettype none
package rrau_pkg;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_DIV_NUM_INIT,
        OP_DIV_DEN_INIT,
        OP_DIV_STEP,
        OP_SAVE_DEN,
        OP_MUL,
        OP_OUT
    } op_t;

    // product selects
    localparam logic [1:0] MUL_AD = 2'd0;
    localparam logic [1:0] MUL_CB = 2'd1;
    localparam logic [1:0] MUL_BD = 2'd2;
    localparam logic [1:0] MUL_AC = 2'd3;

    typedef struct packed {
        op_t        op;
        logic       frac;
        logic [1:0] mul_sel;
    } cmd_t;

    typedef struct packed {
        logic zero_den;
        logic skip;
        logic gcd_done;
        logic div_done;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/rrau_ctrl.sv
`default_nettype none
module rrau_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire rrau_pkg::status_t sts,
    output rrau_pkg::cmd_t       cmd
);
    import rrau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_GCD_INIT, S_GCD_RUN, S_DIV_NUM, S_DIV_DEN, S_MUL, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       frac_reg, frac_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic       mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // sequencing and command decode
    always_comb begin
        state_next  = state_reg;
        frac_next   = frac_reg;
        mcnt_next   = mcnt_reg;
        mvalid_next = mvalid_reg;
        cmd.op      = OP_NONE;
        cmd.frac    = frac_reg;
        cmd.mul_sel = mcnt_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                frac_next = 1'b0;
                mcnt_next = 2'd0;
                state_next = sts.zero_den ? S_DONE : S_GCD_INIT;
            end
            S_GCD_INIT: begin
                if (sts.skip) begin
                    if (frac_reg) begin
                        state_next = S_MUL;
                    end else begin
                        frac_next = 1'b1;
                    end
                end else begin
                    cmd.op     = OP_GCD_INIT;
                    state_next = S_GCD_RUN;
                end
            end
            S_GCD_RUN: begin
                if (sts.gcd_done) begin
                    cmd.op     = OP_DIV_NUM_INIT;
                    state_next = S_DIV_NUM;
                end else begin
                    cmd.op = OP_GCD_STEP;
                end
            end
            S_DIV_NUM: begin
                if (sts.div_done) begin
                    cmd.op     = OP_DIV_DEN_INIT;
                    state_next = S_DIV_DEN;
                end else begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            S_DIV_DEN: begin
                if (sts.div_done) begin
                    cmd.op = OP_SAVE_DEN;
                    if (frac_reg) begin
                        state_next = S_MUL;
                    end else begin
                        frac_next  = 1'b1;
                        state_next = S_GCD_INIT;
                    end
                end else begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            S_MUL: begin
                cmd.op    = OP_MUL;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == MUL_AC) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.op      = OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            frac_reg   <= 1'b0;
            mcnt_reg   <= 2'd0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            frac_reg   <= frac_next;
            mcnt_reg   <= mcnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rrau_dpath.sv
`default_nettype none
module rrau_dpath #(
    parameter int DATA_WIDTH = 16,
    parameter int IN_W       = ((4 * DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((15 * DATA_WIDTH + 2 + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic [IN_W-1:0]  in_data,
    input  wire rrau_pkg::cmd_t   cmd,
    output rrau_pkg::status_t     sts,
    output logic [OUT_W-1:0]      out_data,
    output logic                  out_err
);
    import rrau_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int SH_W = $clog2(W + 1);
    localparam int FLD_W = 15 * W + 2;

    logic signed [W-1:0]   a_reg, b_reg, c_reg, d_reg;
    logic [W-1:0]          u_reg, v_reg, g_reg, rem_reg, quo_reg;
    logic [SH_W-1:0]       sh_reg, cnt_reg;
    logic                  neg_reg;
    logic signed [2*W-1:0] ad_reg, cb_reg, bd_reg, ac_reg;
    logic [FLD_W-1:0]      res_reg;
    logic                  err_reg;

    // current fraction operands
    logic signed [W-1:0] cur_num, cur_den;
    logic [W-1:0]        mag, g_val, quo_signed;
    logic [W:0]          r2;
    logic                fits;
    logic signed [W-1:0] mul_x, mul_y;
    logic signed [2*W:0] sum_val;
    logic signed [W:0]   neg_val;

    assign cur_num = cmd.frac ? c_reg : a_reg;
    assign cur_den = cmd.frac ? d_reg : b_reg;
    assign mag     = cur_num[W-1] ? W'(-cur_num) : W'(cur_num);
    assign g_val   = (u_reg == '0) ? v_reg : W'(u_reg << sh_reg);
    assign r2      = {rem_reg, quo_reg[W-1]};
    assign fits    = (r2 >= {1'b0, g_reg});
    assign quo_signed = neg_reg ? W'(-quo_reg) : quo_reg;

    assign sts.zero_den = (b_reg == '0) || (d_reg == '0);
    assign sts.skip     = (cur_den < $signed(W'(2)));
    assign sts.gcd_done = (u_reg == v_reg) || (u_reg == '0);
    assign sts.div_done = (cnt_reg == SH_W'(W));

    // multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_AD:  begin mul_x = a_reg; mul_y = d_reg; end
            MUL_CB:  begin mul_x = c_reg; mul_y = b_reg; end
            MUL_BD:  begin mul_x = b_reg; mul_y = d_reg; end
            default: begin mul_x = a_reg; mul_y = c_reg; end
        endcase
    end

    assign sum_val = (2*W+1)'(ad_reg) + (2*W+1)'(cb_reg);
    assign neg_val = -((W+1)'(a_reg));

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                a_reg <= in_data[W-1:0];
                b_reg <= in_data[2*W-1:W];
                c_reg <= in_data[3*W-1:2*W];
                d_reg <= in_data[4*W-1:3*W];
            end
            OP_GCD_INIT: begin
                u_reg  <= mag;
                v_reg  <= W'(cur_den);
                sh_reg <= '0;
            end
            OP_GCD_STEP: begin
                // one binary gcd step
                if (!u_reg[0] && !v_reg[0]) begin
                    u_reg  <= u_reg >> 1;
                    v_reg  <= v_reg >> 1;
                    sh_reg <= sh_reg + SH_W'(1);
                end else if (!u_reg[0]) begin
                    u_reg <= u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_reg <= v_reg >> 1;
                end else if (u_reg > v_reg) begin
                    u_reg <= u_reg - v_reg;
                end else begin
                    v_reg <= v_reg - u_reg;
                end
            end
            OP_DIV_NUM_INIT: begin
                g_reg   <= g_val;
                neg_reg <= cur_num[W-1];
                quo_reg <= mag;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                // restoring division, one quotient bit a cycle
                rem_reg <= fits ? W'(r2 - {1'b0, g_reg}) : W'(r2);
                quo_reg <= {quo_reg[W-2:0], fits};
                cnt_reg <= cnt_reg + SH_W'(1);
            end
            OP_DIV_DEN_INIT: begin
                if (cmd.frac) begin
                    c_reg <= quo_signed;
                end else begin
                    a_reg <= quo_signed;
                end
                quo_reg <= W'(cur_den);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_SAVE_DEN: begin
                if (cmd.frac) begin
                    d_reg <= quo_reg;
                end else begin
                    b_reg <= quo_reg;
                end
            end
            OP_MUL: begin
                case (cmd.mul_sel)
                    MUL_AD:  ad_reg <= mul_x * mul_y;
                    MUL_CB:  cb_reg <= mul_x * mul_y;
                    MUL_BD:  bd_reg <= mul_x * mul_y;
                    default: ac_reg <= mul_x * mul_y;
                endcase
            end
            OP_OUT: begin
                err_reg <= sts.zero_den;
                if (sts.zero_den) begin
                    res_reg <= '0;
                end else begin
                    res_reg <= {cb_reg, ad_reg, ac_reg, bd_reg, sum_val, neg_val,
                                d_reg, c_reg, b_reg, a_reg};
                end
            end
            default: ;
        endcase
    end

    assign out_data = OUT_W'(res_reg);
    assign out_err  = err_reg;

endmodule
`default_nettype wire

// File: rtl/rational_reduce_and_arith_unit.sv
// a zero denominator skips reduction and arithmetic and goes straight to the result
// each reduction: gcd setup, binary gcd steps, then two restoring divides by the gcd
// one request at a time; the next is accepted in the cycle after the result is registered
// products come from one shared multiplier, one per cycle
// a finished result waits in the output register while the next request is taken
// aresetn is synchronous, active low; it clears the controller and the output valid
`default_nettype none
module rational_reduce_and_arith_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // num_a, den_a, num_b, den_b
    input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // red_num_a, red_den_a, red_num_b, red_den_b, neg_num, sum_num,
    // sum_den, prod_num, quot_num, quot_den
    output logic [((15*DATA_WIDTH+2+7)/8)*8-1:0] m_tdata,
    // error
    output logic [0:0] m_tuser
);
    import rrau_pkg::*;

    cmd_t    cmd;
    status_t sts;

    rrau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrau_dpath #(.DATA_WIDTH(DATA_WIDTH)) u_dpath (
        .aclk     (aclk),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata),
        .out_err  (m_tuser[0])
    );

endmodule
`default_nettype wire

// File: rtl/rrau_checker.sv
`default_nettype none
`include "rational_reduce_and_arith_unit_assert.svh"
module rrau_checker #(
    parameter int DATA_WIDTH = 16
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((15*DATA_WIDTH+2+7)/8)*8-1:0] m_tdata,
    input wire logic [0:0] m_tuser
);
    // a stalled result stays offered
    `RRAU_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // an error result carries all-zero data
    `RRAU_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    // one request in flight: no accept right after an accept
    `RRAU_ASSERT_NEXT(a_one, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // reset drops the result valid
    `RRAU_ASSERT_ALWAYS(a_rst, aclk, !aresetn, !m_tvalid)
endmodule

bind rational_reduce_and_arith_unit rrau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
`default_nettype wire
